[hw/rtl/prsa_pkg.sv]
// Package for the peer roster slot assigner: sizes, codes and transaction types.
// Used by peer_roster_slot_assigner_unit and the testbench; depends on nothing else.
`default_nettype none
package prsa_pkg;

   localparam int PEER_ENTRIES = 4;
   localparam int ENTRY_W      = (PEER_ENTRIES > 1) ? $clog2(PEER_ENTRIES) : 1;
   localparam int SCAN_W       = $clog2(PEER_ENTRIES + 1);
   localparam int MAX_SLOTS    = 4;
   localparam int SLOT_W       = 2;
   localparam int TMO_W        = 42;

   localparam logic [7:0]       SLOT_AUTO      = 8'hFF;
   localparam logic [15:0]      DEST_BROADCAST = 16'hFFFF;
   localparam logic [TMO_W-1:0] MS_TO_US       = TMO_W'(1000);
   localparam logic [31:0]      MIN_TIMEOUT    = 32'd100;

   localparam logic [1:0] FUNC_OBSERVE = 2'd0;
   localparam logic [1:0] FUNC_REFRESH = 2'd1;
   localparam logic [1:0] FUNC_LOOKUP  = 2'd2;
   localparam logic [1:0] FUNC_NOP     = 2'd3;

   localparam logic [2:0] CSR_LOCAL_UID  = 3'd0;
   localparam logic [2:0] CSR_LOCAL_PREF = 3'd1;
   localparam logic [2:0] CSR_TIMEOUT_MS = 3'd2;
   localparam logic [2:0] CSR_MODE       = 3'd3;
   localparam logic [2:0] CSR_SLOTS      = 3'd4;

   typedef struct packed {
      logic [1:0]  func;
      logic [62:0] now_us;
      logic [63:0] node_id;
      logic [7:0]  peer_mode;
      logic [7:0]  peer_preferred;
      logic        is_data;
      logic [15:0] dest_slot;
      logic [15:0] query_slot;
   } req_type;

   typedef struct packed {
      logic       accepted;
      logic       deliver;
      logic [1:0] source_slot;
      logic       local_assigned;
      logic [1:0] local_slot;
      logic [1:0] client_count;
      logic       peer_found;
      logic [1:0] peer_entry;
   } rsp_type;

   typedef struct packed {
      logic [63:0] id;
      logic [7:0]  mode;
      logic [7:0]  pref;
      logic [62:0] seen;
   } entry_rec_type;

   localparam int ENTRY_REC_W = $bits(entry_rec_type);

endpackage
`default_nettype wire

[hw/rtl/prsa_ram.sv]
// Generic single-port-write, single-port-read RAM with a registered read.
// Stand-alone; holds the peer table records.
`default_nettype none
module prsa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  wire logic                                        clock,
   input  wire logic                                        wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                            wr_data,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                            rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule
`default_nettype wire

[hw/rtl/peer_roster_slot_assigner_unit.sv]
// Peer roster slot assigner: sequencer around the peer table RAM (prsa_ram).
// Depends on prsa_pkg for sizes, codes and transaction types.
// An observe steps through ST_MARK, ST_MARK_WR, ST_EXPIRE, ST_ROSTER, ST_RANK, ST_PASS1,
// ST_PASS2 and ST_FINISH; a refresh starts at ST_EXPIRE, a lookup at ST_ROSTER and ends in
// ST_LOOKUP; other items answer from ST_IDLE. One item at a time; table walks do one RAM read
// per entry per pass. Busy falls with the result strobe: a new item is taken while it is high.
// The result strobe lasts one cycle and cannot be stalled. Reset is synchronous and
// clears the table's active bits and the slot state; RAM contents need no clearing.
`default_nettype none
module peer_roster_slot_assigner_unit
   import prsa_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    start,
   output logic         busy,
   input  wire req_type req_data,
   output logic         rsp_valid,
   output rsp_type      rsp_data,
   input  wire logic    csr_we,
   input  wire logic [2:0]  csr_index,
   input  wire logic [63:0] csr_wdata
);

   typedef enum logic [3:0] {
      ST_IDLE, ST_MARK, ST_MARK_WR, ST_EXPIRE, ST_ROSTER,
      ST_RANK, ST_PASS1, ST_PASS2, ST_FINISH, ST_LOOKUP
   } state_type;

   state_type state_ff, state_in;
   req_type   req_ff, req_in;
   logic [SCAN_W-1:0] cnt_ff, cnt_in;
   logic [TMO_W-1:0]  tmo_ff, tmo_in;
   logic [PEER_ENTRIES-1:0] active_ff, active_in;

   logic [63:0] luid_ff, luid_in;
   logic [7:0]  lpref_ff, lpref_in;
   logic [31:0] tmo_ms_ff, tmo_ms_in;
   logic [7:0]  mode_ff, mode_in;
   logic [2:0]  slots_ff, slots_in;

   logic               hit_ok_ff, hit_ok_in, free_ok_ff, free_ok_in, old_ok_ff, old_ok_in;
   logic [ENTRY_W-1:0] hit_idx_ff, hit_idx_in, free_idx_ff, free_idx_in;
   logic [ENTRY_W-1:0] old_idx_ff, old_idx_in;
   logic [62:0]        old_time_ff, old_time_in;

   logic [63:0]        mem_id_ff     [PEER_ENTRIES];
   logic [63:0]        mem_id_in     [PEER_ENTRIES];
   logic               mem_pok_ff    [PEER_ENTRIES];
   logic               mem_pok_in    [PEER_ENTRIES];
   logic [SLOT_W-1:0]  mem_pref_ff   [PEER_ENTRIES];
   logic [SLOT_W-1:0]  mem_pref_in   [PEER_ENTRIES];
   logic [ENTRY_W-1:0] mem_entry_ff  [PEER_ENTRIES];
   logic [ENTRY_W-1:0] mem_entry_in  [PEER_ENTRIES];
   logic [ENTRY_W-1:0] order_ff      [PEER_ENTRIES];
   logic [ENTRY_W-1:0] order_in      [PEER_ENTRIES];
   logic               placed_ff     [PEER_ENTRIES];
   logic               placed_in     [PEER_ENTRIES];
   logic [SLOT_W-1:0]  mslot_ff      [PEER_ENTRIES];
   logic [SLOT_W-1:0]  mslot_in      [PEER_ENTRIES];
   logic               mem_found     [PEER_ENTRIES];
   logic [MAX_SLOTS-1:0] used_ff, used_in;
   logic [SCAN_W-1:0]  mem_n_ff, mem_n_in;
   logic [2:0]         count_ff, count_in;

   logic       have_ff, have_in;
   logic [1:0] own_ff, own_in, ccount_ff, ccount_in;
   logic       look_ok_ff, look_ok_in;
   logic [ENTRY_W-1:0] look_idx_ff, look_idx_in;

   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_in;

   logic [2:0]          slot_lim;
   logic                scan_last;
   logic [ENTRY_W-1:0]  ent_idx;
   logic                ent_act;
   entry_rec_type       rd_rec;
   logic [ENTRY_REC_W-1:0] rd_raw;
   logic [62:0]         age;
   logic [ENTRY_W-1:0]  mark_sel;
   logic [ENTRY_W-1:0]  rank_val;
   logic [ENTRY_W-1:0]  cur_m;
   logic                free_ok;
   logic [SLOT_W-1:0]   open_slot;
   logic                fin_have;
   logic                fin_dlv;
   logic [SLOT_W-1:0]   fin_src;
   logic                lk_f;
   logic [SLOT_W-1:0]   lk_s;
   entry_rec_type       wr_rec;

   prsa_ram #(
      .WIDTH (ENTRY_REC_W),
      .DEPTH (PEER_ENTRIES)
   ) u_table (
      .clock   (clock),
      .wr_en   (state_ff == ST_MARK_WR),
      .wr_addr (mark_sel),
      .wr_data (wr_rec),
      .rd_addr (cnt_ff[ENTRY_W-1:0]),
      .rd_data (rd_raw)
   );

   assign rd_rec    = entry_rec_type'(rd_raw);
   assign wr_rec    = '{id: req_ff.node_id, mode: req_ff.peer_mode,
                        pref: req_ff.peer_preferred, seen: req_ff.now_us};
   assign scan_last = (cnt_ff == SCAN_W'(PEER_ENTRIES));
   assign ent_idx   = ENTRY_W'(cnt_ff - SCAN_W'(1));
   assign ent_act   = (cnt_ff != '0) && active_ff[ent_idx];
   assign age       = req_ff.now_us - rd_rec.seen;
   assign cur_m     = cnt_ff[ENTRY_W-1:0];
   assign mark_sel  = hit_ok_ff ? hit_idx_ff : (free_ok_ff ? free_idx_ff : old_idx_ff);

   always_comb begin
      slot_lim = (slots_ff > 3'(MAX_SLOTS)) ? 3'(MAX_SLOTS) : slots_ff;
      if (int'(slot_lim) > PEER_ENTRIES) begin
         slot_lim = 3'(PEER_ENTRIES);
      end
   end

   // A member counts as assigned only inside the window of filled slots.
   always_comb begin
      for (int m = 0; m < PEER_ENTRIES; m++) begin
         mem_found[m] = placed_ff[m] && ({1'b0, mslot_ff[m]} < count_ff);
      end
   end

   always_comb begin
      rank_val = '0;
      for (int j = 0; j < PEER_ENTRIES; j++) begin
         if ((SCAN_W'(j) < mem_n_ff) && (ENTRY_W'(j) != cur_m) &&
             (mem_id_ff[j] < mem_id_ff[cur_m])) begin
            rank_val = rank_val + ENTRY_W'(1);
         end
      end
   end

   always_comb begin
      free_ok   = 1'b0;
      open_slot = '0;
      for (int j = MAX_SLOTS - 1; j >= 0; j--) begin
         if ((3'(j) < slot_lim) && !used_ff[j]) begin
            free_ok   = 1'b1;
            open_slot = SLOT_W'(j);
         end
      end
   end

   always_comb begin
      fin_have = mem_found[0];
      fin_dlv  = 1'b0;
      fin_src  = '0;
      for (int m = 1; m < PEER_ENTRIES; m++) begin
         if ((req_ff.func == FUNC_OBSERVE) && (SCAN_W'(m) < mem_n_ff) &&
             (mem_entry_ff[m] == hit_idx_ff) && mem_found[m] &&
             req_ff.is_data && fin_have &&
             ((req_ff.dest_slot == DEST_BROADCAST) ||
              (req_ff.dest_slot == 16'(mslot_ff[0])))) begin
            fin_dlv = 1'b1;
            fin_src = mslot_ff[m];
         end
      end
   end

   // Slot held by the identifier of the entry now coming out of the RAM.
   always_comb begin
      lk_f = 1'b0;
      lk_s = '0;
      if (rd_rec.id == luid_ff) begin
         lk_f = mem_found[0];
         lk_s = mslot_ff[0];
      end else begin
         for (int m = 1; m < PEER_ENTRIES; m++) begin
            if ((SCAN_W'(m) < mem_n_ff) && (mem_entry_ff[m] == ent_idx)) begin
               lk_f = mem_found[m];
               lk_s = mslot_ff[m];
            end
         end
      end
   end

   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      cnt_in       = cnt_ff;
      tmo_in       = tmo_ff;
      active_in    = active_ff;
      luid_in      = luid_ff;
      lpref_in     = lpref_ff;
      tmo_ms_in    = tmo_ms_ff;
      mode_in      = mode_ff;
      slots_in     = slots_ff;
      hit_ok_in    = hit_ok_ff;
      hit_idx_in   = hit_idx_ff;
      free_ok_in   = free_ok_ff;
      free_idx_in  = free_idx_ff;
      old_ok_in    = old_ok_ff;
      old_idx_in   = old_idx_ff;
      old_time_in  = old_time_ff;
      mem_id_in    = mem_id_ff;
      mem_pok_in   = mem_pok_ff;
      mem_pref_in  = mem_pref_ff;
      mem_entry_in = mem_entry_ff;
      order_in     = order_ff;
      placed_in    = placed_ff;
      mslot_in     = mslot_ff;
      used_in      = used_ff;
      mem_n_in     = mem_n_ff;
      count_in     = count_ff;
      have_in      = have_ff;
      own_in       = own_ff;
      ccount_in    = ccount_ff;
      look_ok_in   = look_ok_ff;
      look_idx_in  = look_idx_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;

      if (csr_we) begin
         unique case (csr_index)
            CSR_LOCAL_UID:  luid_in   = (csr_wdata != '0) ? csr_wdata : 64'd1;
            CSR_LOCAL_PREF: lpref_in  = csr_wdata[7:0];
            CSR_TIMEOUT_MS: tmo_ms_in = (csr_wdata[31:0] < MIN_TIMEOUT) ?
                                        MIN_TIMEOUT : csr_wdata[31:0];
            CSR_MODE:       mode_in   = csr_wdata[7:0];
            CSR_SLOTS:      slots_in  = csr_wdata[2:0];
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               req_in = req_data;
               tmo_in = TMO_W'(tmo_ms_ff) * MS_TO_US;
               cnt_in = '0;
               look_ok_in  = 1'b0;
               look_idx_in = '0;
               if (req_data.func == FUNC_OBSERVE && req_data.node_id != '0 &&
                   req_data.node_id != luid_ff && req_data.peer_mode == mode_ff) begin
                  state_in = ST_MARK;
               end else if (req_data.func == FUNC_REFRESH) begin
                  state_in = ST_EXPIRE;
               end else if (req_data.func == FUNC_LOOKUP) begin
                  state_in = ST_ROSTER;
               end else begin
                  // Rejected observe or no-op: report the stored state.
                  rsp_valid_in = 1'b1;
                  rsp_in = '{accepted: 1'b0, deliver: 1'b0, source_slot: '0,
                             local_assigned: have_ff, local_slot: own_ff,
                             client_count: ccount_ff, peer_found: 1'b0, peer_entry: '0};
               end
            end
         end

         ST_MARK: begin
            if (cnt_ff == '0) begin
               hit_ok_in  = 1'b0;
               free_ok_in = 1'b0;
               old_ok_in  = 1'b0;
            end else begin
               if (ent_act && rd_rec.id == req_ff.node_id && !hit_ok_ff) begin
                  hit_ok_in  = 1'b1;
                  hit_idx_in = ent_idx;
               end
               if (!ent_act && !free_ok_ff) begin
                  free_ok_in  = 1'b1;
                  free_idx_in = ent_idx;
               end
               if (ent_act && (!old_ok_ff || rd_rec.seen < old_time_ff)) begin
                  old_ok_in   = 1'b1;
                  old_idx_in  = ent_idx;
                  old_time_in = rd_rec.seen;
               end
            end
            cnt_in = cnt_ff + SCAN_W'(1);
            if (scan_last) begin
               state_in = ST_MARK_WR;
            end
         end

         ST_MARK_WR: begin
            active_in[mark_sel] = 1'b1;
            hit_idx_in = mark_sel;
            cnt_in     = '0;
            state_in   = ST_EXPIRE;
         end

         ST_EXPIRE: begin
            if (ent_act && req_ff.now_us >= rd_rec.seen && age > 63'(tmo_ff)) begin
               active_in[ent_idx] = 1'b0;
            end
            cnt_in = cnt_ff + SCAN_W'(1);
            if (scan_last) begin
               cnt_in   = '0;
               state_in = ST_ROSTER;
            end
         end

         ST_ROSTER: begin
            if (cnt_ff == '0) begin
               mem_n_in       = SCAN_W'(1);
               mem_id_in[0]   = luid_ff;
               mem_pok_in[0]  = lpref_ff < {5'b0, slot_lim};
               mem_pref_in[0] = lpref_ff[SLOT_W-1:0];
               mem_entry_in[0] = '0;
               used_in  = '0;
               count_in = '0;
               for (int m = 0; m < PEER_ENTRIES; m++) begin
                  placed_in[m] = 1'b0;
               end
            end else if (ent_act && rd_rec.id != luid_ff && rd_rec.mode == mode_ff &&
                         mem_n_ff < SCAN_W'(PEER_ENTRIES)) begin
               mem_id_in[mem_n_ff[ENTRY_W-1:0]]    = rd_rec.id;
               mem_pok_in[mem_n_ff[ENTRY_W-1:0]]   = rd_rec.pref < {5'b0, slot_lim};
               mem_pref_in[mem_n_ff[ENTRY_W-1:0]]  = rd_rec.pref[SLOT_W-1:0];
               mem_entry_in[mem_n_ff[ENTRY_W-1:0]] = ent_idx;
               mem_n_in = mem_n_ff + SCAN_W'(1);
            end
            cnt_in = cnt_ff + SCAN_W'(1);
            if (scan_last) begin
               cnt_in   = '0;
               state_in = ST_RANK;
            end
         end

         // Identifiers are distinct, so each member's rank is its sorted position.
         ST_RANK: begin
            if (SCAN_W'(cur_m) < mem_n_ff) begin
               order_in[rank_val] = cur_m;
            end
            cnt_in = cnt_ff + SCAN_W'(1);
            if (cnt_ff == SCAN_W'(PEER_ENTRIES - 1)) begin
               cnt_in   = '0;
               state_in = ST_PASS1;
            end
         end

         ST_PASS1: begin
            if (cnt_ff < mem_n_ff && mem_pok_ff[order_ff[cur_m]] &&
                !used_ff[mem_pref_ff[order_ff[cur_m]]]) begin
               used_in[mem_pref_ff[order_ff[cur_m]]] = 1'b1;
               placed_in[order_ff[cur_m]] = 1'b1;
               mslot_in[order_ff[cur_m]]  = mem_pref_ff[order_ff[cur_m]];
               count_in = count_ff + 3'd1;
            end
            cnt_in = cnt_ff + SCAN_W'(1);
            if (cnt_ff == SCAN_W'(PEER_ENTRIES - 1)) begin
               cnt_in   = '0;
               state_in = ST_PASS2;
            end
         end

         ST_PASS2: begin
            if (cnt_ff < mem_n_ff && !placed_ff[order_ff[cur_m]] &&
                count_ff < slot_lim && free_ok) begin
               used_in[open_slot] = 1'b1;
               placed_in[order_ff[cur_m]] = 1'b1;
               mslot_in[order_ff[cur_m]]  = open_slot;
               count_in = count_ff + 3'd1;
            end
            cnt_in = cnt_ff + SCAN_W'(1);
            if (cnt_ff == SCAN_W'(PEER_ENTRIES - 1)) begin
               cnt_in   = '0;
               state_in = ST_FINISH;
            end
         end

         ST_FINISH: begin
            if (req_ff.func == FUNC_LOOKUP) begin
               cnt_in   = '0;
               state_in = ST_LOOKUP;
            end else begin
               have_in   = fin_have;
               own_in    = fin_have ? mslot_ff[0] : 2'd0;
               ccount_in = fin_have ? 2'(count_ff - 3'd1) : 2'd0;
               rsp_valid_in = 1'b1;
               rsp_in = '{accepted: (req_ff.func == FUNC_OBSERVE),
                          deliver: fin_dlv, source_slot: fin_src,
                          local_assigned: fin_have,
                          local_slot: fin_have ? mslot_ff[0] : 2'd0,
                          client_count: fin_have ? 2'(count_ff - 3'd1) : 2'd0,
                          peer_found: 1'b0, peer_entry: '0};
               state_in = ST_IDLE;
            end
         end

         ST_LOOKUP: begin
            if (ent_act && !look_ok_ff && rd_rec.mode == mode_ff && lk_f &&
                req_ff.query_slot == 16'(lk_s)) begin
               look_ok_in  = 1'b1;
               look_idx_in = ent_idx;
            end
            cnt_in = cnt_ff + SCAN_W'(1);
            if (scan_last) begin
               rsp_valid_in = 1'b1;
               rsp_in = '{accepted: 1'b0, deliver: 1'b0, source_slot: '0,
                          local_assigned: have_ff, local_slot: own_ff,
                          client_count: ccount_ff, peer_found: look_ok_in,
                          peer_entry: 2'(look_idx_in)};
               state_in = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      req_ff       <= req_in;
      cnt_ff       <= cnt_in;
      tmo_ff       <= tmo_in;
      hit_ok_ff    <= hit_ok_in;
      hit_idx_ff   <= hit_idx_in;
      free_ok_ff   <= free_ok_in;
      free_idx_ff  <= free_idx_in;
      old_ok_ff    <= old_ok_in;
      old_idx_ff   <= old_idx_in;
      old_time_ff  <= old_time_in;
      mem_id_ff    <= mem_id_in;
      mem_pok_ff   <= mem_pok_in;
      mem_pref_ff  <= mem_pref_in;
      mem_entry_ff <= mem_entry_in;
      order_ff     <= order_in;
      placed_ff    <= placed_in;
      mslot_ff     <= mslot_in;
      used_ff      <= used_in;
      mem_n_ff     <= mem_n_in;
      count_ff     <= count_in;
      look_ok_ff   <= look_ok_in;
      look_idx_ff  <= look_idx_in;
      rsp_ff       <= rsp_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         active_ff    <= '0;
         luid_ff      <= 64'd1;
         lpref_ff     <= SLOT_AUTO;
         tmo_ms_ff    <= 32'd1000;
         mode_ff      <= 8'd0;
         slots_ff     <= 3'd4;
         have_ff      <= 1'b0;
         own_ff       <= 2'd0;
         ccount_ff    <= 2'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         active_ff    <= active_in;
         luid_ff      <= luid_in;
         lpref_ff     <= lpref_in;
         tmo_ms_ff    <= tmo_ms_in;
         mode_ff      <= mode_in;
         slots_ff     <= slots_in;
         have_ff      <= have_in;
         own_ff       <= own_in;
         ccount_ff    <= ccount_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
`default_nettype wire

[tb/tb.sv]
// Self-checking testbench for peer_roster_slot_assigner_unit: directed and random traffic
// checked against a behavioural predictor of the peer table and slot assignment.
// Depends on prsa_pkg for the transaction types and the function and register codes.
`timescale 1ns / 1ps
module tb;
   import prsa_pkg::*;

   localparam int N_ENT     = 4;
   localparam int SETTLE    = 40;
   localparam int MAX_CYCLE = 3000000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   req_type     req_data = '0;
   logic        rsp_valid;
   rsp_type     rsp_data;
   logic        csr_we = 1'b0;
   logic [2:0]  csr_index = CSR_LOCAL_UID;
   logic [63:0] csr_wdata = '0;

   peer_roster_slot_assigner_unit DUT (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_data(rsp_data), .csr_we(csr_we),
      .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Predictor state: configuration and peer table.
   logic [63:0] cfg_uid;
   logic [7:0]  cfg_pref;
   logic [31:0] cfg_tmo_ms;
   logic [7:0]  cfg_mode;
   logic [2:0]  cfg_slots;
   logic        tbl_active [N_ENT];
   logic [63:0] tbl_id [N_ENT];
   logic [7:0]  tbl_mode [N_ENT];
   logic [7:0]  tbl_pref [N_ENT];
   logic [62:0] tbl_seen [N_ENT];
   logic        own_valid;
   logic [1:0]  own_pos;
   logic [1:0]  own_count;
   // Outcome of the latest slot assignment.
   logic [63:0] grant_uid [N_ENT];
   logic        grant_used [N_ENT];
   int          grant_count;

   rsp_type     pending_rsp[$];
   int          fail_count = 0;
   int          cycle_count = 0;
   logic [62:0] clock_us = '0;
   logic [63:0] id_pool [8];

   function automatic int slot_total();
      return (cfg_slots > 4) ? 4 : int'(cfg_slots);
   endfunction

   function automatic bit pref_slot(logic [63:0] uid, output int p);
      int total = slot_total();
      p = 0;
      if (uid == cfg_uid) begin
         if (cfg_pref != SLOT_AUTO && int'(cfg_pref) < total) begin
            p = int'(cfg_pref);
            return 1;
         end
         return 0;
      end
      for (int i = 0; i < N_ENT; i++) begin
         if (!tbl_active[i] || tbl_id[i] != uid || tbl_mode[i] != cfg_mode) continue;
         if (tbl_pref[i] != SLOT_AUTO && int'(tbl_pref[i]) < total) begin
            p = int'(tbl_pref[i]);
            return 1;
         end
         return 0;
      end
      return 0;
   endfunction

   function automatic void assign_slots();
      logic [63:0] roster [N_ENT];
      logic        placed [N_ENT];
      logic [63:0] v;
      int slots = slot_total();
      int n = 0;
      int j, p;
      grant_count = 0;
      for (int i = 0; i < N_ENT; i++) begin
         grant_uid[i] = '0;
         grant_used[i] = 1'b0;
         placed[i] = 1'b0;
         roster[i] = '0;
      end
      if (slots == 0) return;
      roster[n] = cfg_uid;
      n = n + 1;
      for (int i = 0; i < N_ENT && n < N_ENT; i++) begin
         if (!tbl_active[i] || tbl_id[i] == cfg_uid || tbl_mode[i] != cfg_mode) continue;
         roster[n] = tbl_id[i];
         n = n + 1;
      end
      for (int i = 1; i < n; i++) begin
         v = roster[i];
         j = i;
         while (j > 0 && roster[j-1] > v) begin
            roster[j] = roster[j-1];
            j--;
         end
         roster[j] = v;
      end
      for (int i = 0; i < n && grant_count < slots; i++) begin
         if (!pref_slot(roster[i], p) || p >= slots || grant_used[p]) continue;
         grant_used[p] = 1'b1;
         grant_uid[p] = roster[i];
         placed[i] = 1'b1;
         grant_count++;
      end
      for (int i = 0; i < n && grant_count < slots; i++) begin
         if (placed[i]) continue;
         for (int k = 0; k < slots; k++) begin
            if (!grant_used[k]) begin
               grant_used[k] = 1'b1;
               grant_uid[k] = roster[i];
               grant_count++;
               break;
            end
         end
      end
   endfunction

   function automatic bit slot_of(logic [63:0] uid, output int s);
      s = 0;
      for (int i = 0; i < grant_count && i < N_ENT; i++) begin
         if (grant_used[i] && grant_uid[i] == uid) begin
            s = i;
            return 1;
         end
      end
      return 0;
   endfunction

   function automatic void refresh_roster(logic [62:0] now);
      logic [63:0] tmo = 64'(cfg_tmo_ms) * 64'd1000;
      int s;
      for (int i = 0; i < N_ENT; i++)
         if (tbl_active[i] && now >= tbl_seen[i] && 64'(now - tbl_seen[i]) > tmo)
            tbl_active[i] = 1'b0;
      own_valid = 1'b0;
      own_pos = '0;
      own_count = '0;
      if (slot_total() == 0) return;
      assign_slots();
      if (slot_of(cfg_uid, s)) begin
         own_valid = 1'b1;
         own_pos = 2'(s);
         own_count = 2'(grant_count > 0 ? grant_count - 1 : 0);
      end
   endfunction

   function automatic void stamp_peer(req_type r);
      int hit = -1;
      int oldest = -1;
      for (int i = 0; i < N_ENT; i++)
         if (tbl_active[i] && tbl_id[i] == r.node_id) begin
            hit = i;
            break;
         end
      if (hit < 0) begin
         for (int i = 0; i < N_ENT; i++) begin
            if (!tbl_active[i]) begin
               hit = i;
               break;
            end
            if (oldest < 0 || tbl_seen[i] < tbl_seen[oldest]) oldest = i;
         end
         if (hit < 0) hit = oldest;
      end
      tbl_active[hit] = 1'b1;
      tbl_id[hit] = r.node_id;
      tbl_mode[hit] = r.peer_mode;
      tbl_pref[hit] = r.peer_preferred;
      tbl_seen[hit] = r.now_us;
   endfunction

   function automatic rsp_type roster_response(req_type r);
      rsp_type o = '0;
      int s;
      if (r.func == FUNC_OBSERVE) begin
         if (r.node_id != 0 && r.node_id != cfg_uid && r.peer_mode == cfg_mode) begin
            o.accepted = 1'b1;
            stamp_peer(r);
            refresh_roster(r.now_us);
            if (r.is_data && own_valid) begin
               assign_slots();
               if (slot_of(r.node_id, s) &&
                   (r.dest_slot == DEST_BROADCAST || r.dest_slot == 16'(own_pos))) begin
                  o.deliver = 1'b1;
                  o.source_slot = 2'(s);
               end
            end
         end
      end else if (r.func == FUNC_REFRESH) begin
         refresh_roster(r.now_us);
      end else if (r.func == FUNC_LOOKUP) begin
         assign_slots();
         for (int i = 0; i < N_ENT; i++) begin
            if (!tbl_active[i] || tbl_mode[i] != cfg_mode) continue;
            if (slot_of(tbl_id[i], s) && 16'(s) == r.query_slot) begin
               o.peer_found = 1'b1;
               o.peer_entry = 2'(i);
               break;
            end
         end
      end
      o.local_assigned = own_valid;
      o.local_slot = own_pos;
      o.client_count = own_count;
      return o;
   endfunction

   function automatic void model_reset();
      cfg_uid = 64'd1;
      cfg_pref = SLOT_AUTO;
      cfg_tmo_ms = 32'd1000;
      cfg_mode = 8'd0;
      cfg_slots = 3'd4;
      for (int i = 0; i < N_ENT; i++) begin
         tbl_active[i] = 1'b0;
         tbl_id[i] = '0;
         tbl_mode[i] = '0;
         tbl_pref[i] = '0;
         tbl_seen[i] = '0;
      end
      own_valid = 1'b0;
      own_pos = '0;
      own_count = '0;
   endfunction

   // Response checker: the strobe cannot be held off, so each cycle stands alone.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid) begin
         if (pending_rsp.size() == 0) begin
            $error("unexpected response %h", rsp_data);
            fail_count++;
         end else begin
            want = pending_rsp.pop_front();
            if (rsp_data !== want) begin
               if (rsp_data.accepted !== want.accepted)
                  $error("accepted: expected %h, actual %h", want.accepted, rsp_data.accepted);
               if (rsp_data.deliver !== want.deliver)
                  $error("deliver: expected %h, actual %h", want.deliver, rsp_data.deliver);
               if (rsp_data.source_slot !== want.source_slot)
                  $error("source_slot: expected %h, actual %h",
                         want.source_slot, rsp_data.source_slot);
               if (rsp_data.local_assigned !== want.local_assigned)
                  $error("local_assigned: expected %h, actual %h",
                         want.local_assigned, rsp_data.local_assigned);
               if (rsp_data.local_slot !== want.local_slot)
                  $error("local_slot: expected %h, actual %h",
                         want.local_slot, rsp_data.local_slot);
               if (rsp_data.client_count !== want.client_count)
                  $error("client_count: expected %h, actual %h",
                         want.client_count, rsp_data.client_count);
               if (rsp_data.peer_found !== want.peer_found)
                  $error("peer_found: expected %h, actual %h",
                         want.peer_found, rsp_data.peer_found);
               if (rsp_data.peer_entry !== want.peer_entry)
                  $error("peer_entry: expected %h, actual %h",
                         want.peer_entry, rsp_data.peer_entry);
               fail_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > MAX_CYCLE) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // Sends one transaction; start stays high afterwards so back-to-back items need no gap.
   task automatic send_item(req_type r);
      int gap;
      int pick = $urandom_range(0, 99);
      gap = (pick < 65) ? 0 : (pick < 93) ? $urandom_range(1, 3) : $urandom_range(10, 80);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (busy);
      pending_rsp.push_back(roster_response(r));
   endtask

   task automatic drain();
      start <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   // Leaves the write enable high; configure drops it after its last write.
   task automatic write_reg(logic [2:0] idx, logic [63:0] value);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      case (idx)
         CSR_LOCAL_UID:  cfg_uid = (value != 0) ? value : 64'd1;
         CSR_LOCAL_PREF: cfg_pref = value[7:0];
         CSR_TIMEOUT_MS: cfg_tmo_ms = (value[31:0] < MIN_TIMEOUT) ? MIN_TIMEOUT : value[31:0];
         CSR_MODE:       cfg_mode = value[7:0];
         CSR_SLOTS:      cfg_slots = value[2:0];
         default: ;
      endcase
   endtask

   task automatic configure(logic [63:0] uid, logic [7:0] pref, logic [31:0] tmo,
                            logic [7:0] mode, logic [2:0] slots);
      write_reg(CSR_LOCAL_UID, uid);
      write_reg(CSR_LOCAL_PREF, {56'd0, pref});
      write_reg(CSR_TIMEOUT_MS, {32'd0, tmo});
      write_reg(CSR_MODE, {56'd0, mode});
      write_reg(CSR_SLOTS, {61'd0, slots});
      csr_we <= 1'b0;
   endtask

   function automatic req_type make_item(logic [1:0] func, logic [63:0] id, logic [7:0] mode,
                                         logic [7:0] pref, logic data, logic [15:0] dest,
                                         logic [15:0] query);
      req_type r;
      r.func = func;
      r.now_us = clock_us;
      r.node_id = id;
      r.peer_mode = mode;
      r.peer_preferred = pref;
      r.is_data = data;
      r.dest_slot = dest;
      r.query_slot = query;
      return r;
   endfunction

   task automatic test_directed();
      configure(64'd0, 8'd1, 32'd0, 8'd0, 3'd4);   // zero identifier and short timeout clamp
      clock_us = 63'd1000;
      send_item(make_item(FUNC_REFRESH, '0, '0, '0, 1'b0, '0, '0));
      send_item(make_item(FUNC_OBSERVE, 64'd0, 8'd0, SLOT_AUTO, 1'b1, DEST_BROADCAST, '0));
      send_item(make_item(FUNC_OBSERVE, 64'd1, 8'd0, SLOT_AUTO, 1'b1, DEST_BROADCAST, '0));
      send_item(make_item(FUNC_OBSERVE, 64'd5, 8'd7, SLOT_AUTO, 1'b1, DEST_BROADCAST, '0));
      send_item(make_item(FUNC_OBSERVE, 64'd5, 8'd0, 8'd1, 1'b1, DEST_BROADCAST, '0));
      send_item(make_item(FUNC_OBSERVE, '1, 8'd0, 8'd3, 1'b1, 16'd1, '0));
      send_item(make_item(FUNC_OBSERVE, 64'd3, 8'd0, SLOT_AUTO, 1'b1, 16'd0, '0));
      send_item(make_item(FUNC_OBSERVE, 64'd9, 8'd0, 8'd0, 1'b0, 16'd2, '0));
      // Table full: the least recently seen peer is displaced.
      clock_us = 63'd2000;
      send_item(make_item(FUNC_OBSERVE, 64'd7, 8'd0, 8'd2, 1'b1, DEST_BROADCAST, '0));
      for (int q = 0; q < 5; q++)
         send_item(make_item(FUNC_LOOKUP, '0, '0, '0, 1'b0, '0, 16'(q)));
      send_item(make_item(FUNC_LOOKUP, '0, '0, '0, 1'b0, '0, 16'hFFFF));
      send_item(make_item(FUNC_NOP, '1, '1, '1, 1'b1, '1, '1));
      // Time running backwards never expires; two large steps expire everyone, the second just past the bound.
      clock_us = 63'd10;
      send_item(make_item(FUNC_REFRESH, '0, '0, '0, 1'b0, '0, '0));
      clock_us = 63'd102000;
      send_item(make_item(FUNC_REFRESH, '0, '0, '0, 1'b0, '0, '0));
      clock_us = 63'd102001;
      send_item(make_item(FUNC_REFRESH, '0, '0, '0, 1'b0, '0, '0));
      clock_us = '1;
      send_item(make_item(FUNC_OBSERVE, 64'h8000_0000_0000_0000, 8'd0, SLOT_AUTO, 1'b1,
                          DEST_BROADCAST, '0));
      send_item(make_item(FUNC_REFRESH, '0, '0, '0, 1'b0, '0, '0));
      drain();
   endtask

   function automatic req_type random_item();
      req_type r;
      int pick = $urandom_range(0, 99);
      int k;
      pick = $urandom_range(0, 99);
      if (pick < 80) clock_us = clock_us + 63'($urandom_range(0, 300000));
      else if (pick < 95) clock_us = clock_us + 63'($urandom_range(0, 3000000));
      else if (pick < 98) clock_us = clock_us - 63'($urandom_range(0, 500000));
      else clock_us = 63'({$urandom, $urandom});
      r.now_us = clock_us;
      pick = $urandom_range(0, 99);
      r.func = (pick < 55) ? FUNC_OBSERVE : (pick < 72) ? FUNC_REFRESH :
               (pick < 95) ? FUNC_LOOKUP : FUNC_NOP;
      k = $urandom_range(0, 99);
      if (k < 85) r.node_id = id_pool[$urandom_range(0, 7)];
      else if (k < 90) r.node_id = cfg_uid;
      else if (k < 94) r.node_id = '0;
      else r.node_id = {$urandom, $urandom};
      r.peer_mode = ($urandom_range(0, 9) < 8) ? cfg_mode : 8'($urandom);
      k = $urandom_range(0, 9);
      r.peer_preferred = (k < 4) ? SLOT_AUTO : (k < 8) ? 8'($urandom_range(0, 4)) : 8'($urandom);
      r.is_data = ($urandom_range(0, 3) != 0);
      k = $urandom_range(0, 9);
      r.dest_slot = (k < 4) ? DEST_BROADCAST : (k < 8) ? 16'($urandom_range(0, 3)) :
                    16'($urandom);
      r.query_slot = ($urandom_range(0, 9) < 8) ? 16'($urandom_range(0, 4)) : 16'($urandom);
      return r;
   endfunction

   task automatic test_random_phase(logic [63:0] uid, logic [7:0] pref, logic [31:0] tmo,
                                    logic [7:0] mode, logic [2:0] slots, int items);
      configure(uid, pref, tmo, mode, slots);
      id_pool[0] = 64'd2;
      id_pool[1] = 64'd3;
      id_pool[2] = 64'd5;
      id_pool[3] = 64'd8;
      id_pool[4] = 64'h8000_0000_0000_0000;
      id_pool[5] = 64'hFFFF_FFFF_FFFF_FFFE;
      id_pool[6] = '1;
      id_pool[7] = {$urandom, $urandom};
      for (int n = 0; n < items; n++) send_item(random_item());
      drain();
   endtask

   initial begin
      model_reset();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random_phase(64'd1, SLOT_AUTO, 32'd1000, 8'd0, 3'd4, 120);
      test_random_phase(64'd6, 8'd0, 32'd100, 8'hFF, 3'd3, 90);
      test_random_phase('1, 8'd3, 32'hFFFF_FFFF, 8'hA5, 3'd4, 90);
      test_random_phase(64'h8000_0000_0000_0001, 8'd1, 32'd150, 8'd0, 3'd2, 80);
      test_random_phase(64'd4, 8'd200, 32'd500, 8'd3, 3'd1, 70);
      test_random_phase(64'd4, 8'd2, 32'd250, 8'd3, 3'd0, 60);
      test_random_phase(64'd7, 8'd2, 32'd99, 8'd0, 3'd7, 80);
      test_random_phase({$urandom, $urandom}, 8'($urandom), 32'($urandom_range(100, 2000)),
                        8'($urandom), 3'($urandom), 80);
      if (fail_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
